@@ rtl/isf_pkg.sv @@
package isf_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field and counter widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_W     = 2 * PIX_W;

  // Arithmetic widths: box sum up to 9*255, kernel values -2040..2295
  localparam int SUM_W      = 12;
  localparam int KRN_W      = 13;

  // Divide by nine as multiply by ceil(2^16/9) and shift; exact for sums below 2^15
  localparam int DIV9_W     = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [DIV9_W-1:0] DIV9_MULT = DIV9_W'(7282);

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = CFG_IDX_W'(2);

  // Kernel selection
  localparam logic [MODE_W-1:0] MODE_BOX     = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_SHARPEN = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LAPLACE = MODE_W'(2);

  // Per-item window control, decided when the item is accepted
  typedef struct packed {
    logic emit;    // item completes a result
    logic last;    // result is the frame's last pixel
    logic top;     // top window row lies outside the frame
    logic bottom;  // bottom window row lies outside the frame
    logic left;    // left window column lies outside the frame
    logic right;   // right window column lies outside the frame
  } win_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } result_t;

  // Saturate a signed kernel value to 0..255
  function automatic logic [PIX_W-1:0] clip_u8(input logic signed [KRN_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > KRN_W'(255)) begin
      r = '1;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/isf_line_buf.sv @@
module isf_line_buf import isf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [COL_W-1:0] col,
  input  logic [PIX_W-1:0] pix,
  output logic             lb_valid,
  output logic [PIX_W-1:0] upper_pix,
  output logic [PIX_W-1:0] middle_pix,
  output logic [PIX_W-1:0] new_pix
);

  // Both row stores share one word per column: {upper, middle}
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];

  logic              valid_r;
  logic [COL_W-1:0]  col_r;
  logic [PIX_W-1:0]  pix_r;
  logic [LINE_W-1:0] rd_data_r;
  logic              fwd_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic [LINE_W-1:0] line_word;
  logic [LINE_W-1:0] wr_word;

  // Read data, or the word written back in the same cycle (one-column rows)
  assign line_word = fwd_r ? fwd_data_r : rd_data_r;
  assign wr_word   = {line_word[PIX_W-1:0], pix_r};

  // Control stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc;
    end
  end

  // Read at acceptance, write the shifted column back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= line_mem[col];
      col_r     <= col;
      pix_r     <= pix;
    end
    if (valid_r) begin
      line_mem[col_r] <= wr_word;
    end
    fwd_r      <= acc && valid_r && (col == col_r);
    fwd_data_r <= wr_word;
  end

  assign lb_valid   = valid_r;
  assign upper_pix  = line_word[LINE_W-1:PIX_W];
  assign middle_pix = line_word[PIX_W-1:0];
  assign new_pix    = pix_r;

endmodule

@@ rtl/isf_kernel.sv @@
module isf_kernel import isf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              lb_valid,
  input  win_ctl_t          lb_ctl,
  input  logic [PIX_W-1:0]  upper_pix,
  input  logic [PIX_W-1:0]  middle_pix,
  input  logic [PIX_W-1:0]  new_pix,
  input  logic [MODE_W-1:0] mode,
  output logic              push,
  output result_t           result
);

  // 3x3 window, [row top..bottom][column left..right]
  logic [PIX_W-1:0] window_r [3][3];

  logic     s2_valid_r;
  win_ctl_t s2_ctl_r;

  logic                    s3_valid_r;
  logic                    s3_last_r;
  logic                    s3_box_r;
  logic [SUM_W-1:0]        s3_sum_r;
  logic signed [KRN_W-1:0] s3_kval_r;

  logic [PIX_W-1:0]        g [3][3];
  logic [SUM_W-1:0]        box_sum;
  logic signed [KRN_W-1:0] c01, c10, c11, c12, c21;
  logic signed [KRN_W-1:0] sharp_v;
  logic signed [KRN_W-1:0] lap_v;
  logic signed [KRN_W-1:0] kval;
  logic                    is_box;
  logic [SUM_W+DIV9_W-1:0] div_prod;

  // Window shift on every item leaving the line buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          window_r[j][k] <= '0;
        end
      end
    end else if (lb_valid) begin
      for (int j = 0; j < 3; j++) begin
        window_r[j][0] <= window_r[j][1];
        window_r[j][1] <= window_r[j][2];
      end
      window_r[0][2] <= upper_pix;
      window_r[1][2] <= middle_pix;
      window_r[2][2] <= new_pix;
    end
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= lb_valid && lb_ctl.emit;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Zero padding at frame borders
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        g[j][k] = window_r[j][k];
        if ((j == 0 && s2_ctl_r.top) || (j == 2 && s2_ctl_r.bottom) ||
            (k == 0 && s2_ctl_r.left) || (k == 2 && s2_ctl_r.right)) begin
          g[j][k] = '0;
        end
      end
    end
  end

  // Box sum
  always_comb begin
    box_sum = '0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        box_sum = box_sum + SUM_W'(g[j][k]);
      end
    end
  end

  // Cross-shaped kernels
  assign c01 = signed'(KRN_W'(g[0][1]));
  assign c10 = signed'(KRN_W'(g[1][0]));
  assign c11 = signed'(KRN_W'(g[1][1]));
  assign c12 = signed'(KRN_W'(g[1][2]));
  assign c21 = signed'(KRN_W'(g[2][1]));

  assign sharp_v = KRN_W'(9) * c11 - KRN_W'(3) * c01 - c10 - KRN_W'(3) * c12 - c21;
  assign lap_v   = KRN_W'(4) * c11 - c01 - c10 - c12 - c21;

  always_comb begin
    case (mode)
      MODE_SHARPEN: begin
        kval   = sharp_v;
        is_box = 1'b0;
      end
      MODE_LAPLACE: begin
        kval   = lap_v;
        is_box = 1'b0;
      end
      default: begin
        kval   = sharp_v;
        is_box = 1'b1;
      end
    endcase
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (lb_valid) begin
      s2_ctl_r <= lb_ctl;
    end
    s3_last_r <= s2_ctl_r.last;
    s3_box_r  <= is_box;
    s3_sum_r  <= box_sum;
    s3_kval_r <= kval;
  end

  // Divide the box sum by nine, or saturate the kernel value
  assign div_prod = SUM_W'(s3_sum_r) * DIV9_MULT;

  assign push            = s3_valid_r;
  assign result.filtered = s3_box_r ? div_prod[DIV9_SHIFT +: PIX_W] : clip_u8(s3_kval_r);
  assign result.frame_end = s3_last_r;

endmodule

@@ rtl/isf_out_fifo.sv @@
module isf_out_fifo import isf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  result_t                slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  cnt_r;

  // Pointers and fill level; the credit count upstream keeps it from overflowing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

@@ rtl/image_stencil_3x3_filter_top.sv @@
// 3x3 stencil filter for an 8-bit gray raster stream with zero padding at the
// frame borders. Kernel 0 (or 3) is the box average (sum / 9, floored), 1 the
// sharpen kernel [0 -3 0; -1 9 -3; 0 -1 0], 2 the 4-neighbour Laplacian; every
// result is clipped to 0..255. Pixels are sent in raster order; the result for
// a pixel comes out when the pixel width+1 places later is accepted, so after
// each frame send width+1 padding transactions (values ignored) to flush it.
// frame_end marks the frame's last result. One pixel is accepted per clock
// while in_ready is high; the two row stores sit in a single 1024 x 16
// single-cycle-read RAM, read when a pixel is accepted, written back the next
// cycle. Results pass the line buffer, window and kernel registers, then an
// 8-entry output queue; in_ready drops only when that queue and the pipeline
// hold 8 pending results. Writing frame_width or frame_height restarts the
// frame; change registers only while no pixel is in flight. Widths 1025..2047
// act as 1024, heights above 4096 as 4096, and zero as one.
module image_stencil_3x3_filter_top import isf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_filtered,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [WID_W-1:0]      width_r;
  logic [HGT_W-1:0]      height_r;
  logic [MODE_W-1:0]     mode_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [HGT_W-1:0]      row_r, row_nxt;
  logic [FIFO_CNT_W-1:0] pend_r, pend_nxt;
  win_ctl_t              ctl_r;

  logic                  acc;
  logic                  pop;
  logic                  first_col;
  logic                  pad_row;
  logic [WID_W-1:0]      col_inc;
  logic [WID_W-1:0]      wr_width;
  logic [HGT_W-1:0]      wr_height;
  logic [PIX_W-1:0]      pix_in;
  win_ctl_t              ctl;

  logic                  lb_valid;
  logic [PIX_W-1:0]      upper_pix, middle_pix, new_pix;
  logic                  push;
  result_t               push_data;
  result_t               head;

  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Clamp register writes into the usable range
  always_comb begin
    wr_width = cfg_wdata[WID_W-1:0];
    if (wr_width == '0) begin
      wr_width = WID_W'(1);
    end else if (wr_width > WID_W'(MAX_WIDTH)) begin
      wr_width = WID_W'(MAX_WIDTH);
    end
    wr_height = cfg_wdata[HGT_W-1:0];
    if (wr_height == '0) begin
      wr_height = HGT_W'(1);
    end else if (wr_height > HGT_W'(MAX_HEIGHT)) begin
      wr_height = HGT_W'(MAX_HEIGHT);
    end
  end

  // Window position of the result this pixel completes
  assign first_col = (col_r == '0);
  assign pad_row   = (row_r >= height_r);
  assign pix_in    = pad_row ? '0 : in_pixel;

  always_comb begin
    ctl.emit   = (row_r >= HGT_W'(2)) || ((row_r == HGT_W'(1)) && !first_col);
    ctl.last   = (row_r > height_r) && first_col;
    ctl.top    = first_col ? (row_r == HGT_W'(2)) : (row_r == HGT_W'(1));
    ctl.bottom = first_col ? (row_r > height_r) : (row_r >= height_r);
    ctl.left   = first_col ? (width_r == WID_W'(1)) : (col_r == COL_W'(1));
    ctl.right  = first_col;
  end

  // Raster counters
  assign col_inc = WID_W'(col_r) + WID_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + HGT_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // Results owed downstream, pipeline plus queue
  assign pend_nxt = pend_r + FIFO_CNT_W'(acc && ctl.emit) - FIFO_CNT_W'(pop);
  assign in_ready = (pend_r < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(256);
      height_r <= HGT_W'(256);
      mode_r   <= MODE_BOX;
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= wr_width;
          CFG_FRAME_HEIGHT: height_r <= wr_height;
          CFG_KERNEL_MODE:  mode_r   <= cfg_wdata[MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Control travels alongside the RAM read
  always_ff @(posedge clk) begin
    if (acc) begin
      ctl_r <= ctl;
    end
  end

  isf_line_buf u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .col        (col_r),
    .pix        (pix_in),
    .lb_valid   (lb_valid),
    .upper_pix  (upper_pix),
    .middle_pix (middle_pix),
    .new_pix    (new_pix)
  );

  isf_kernel u_kernel (
    .clk        (clk),
    .rst_n      (rst_n),
    .lb_valid   (lb_valid),
    .lb_ctl     (ctl_r),
    .upper_pix  (upper_pix),
    .middle_pix (middle_pix),
    .new_pix    (new_pix),
    .mode       (mode_r),
    .push       (push),
    .result     (push_data)
  );

  isf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_filtered  = head.filtered;
  assign out_frame_end = head.frame_end;

endmodule

@@ rtl/isf_checker.sv @@
module isf_checker import isf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [PIX_W-1:0]      in_pixel,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIX_W-1:0]      out_filtered,
  input logic                  out_frame_end,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_filtered) && $stable(out_frame_end))
    else $error("result payload changed while stalled");

  // Out of reset the block takes pixels and owes nothing
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not empty after reset");

  // Right after reset no result appears, since none can have passed the pipeline yet
  a_no_early_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind image_stencil_3x3_filter_top isf_checker u_isf_checker (.*);
